// ===== hw/rtl/sts_pkg.sv =====
// Shared types, constants and lookup functions for the sphere triangle subdivider.
// Used by sts_norm_unit and sphere_triangle_subdivider; depends on nothing else.
package sts_pkg;

  localparam int COORD_W         = 16;
  localparam int MAX_DEPTH_DEF   = 3;
  localparam int FRAC_BITS_DEF   = 14;
  localparam int SLOTS_PER_LEVEL = 6;   // three vertices, then m12, m23, m31
  localparam int MID_BASE        = 3;
  localparam logic [1:0] CHILD_LAST = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] v1_x;
    logic signed [COORD_W-1:0] v1_y;
    logic signed [COORD_W-1:0] v1_z;
    logic signed [COORD_W-1:0] v2_x;
    logic signed [COORD_W-1:0] v2_y;
    logic signed [COORD_W-1:0] v2_z;
    logic signed [COORD_W-1:0] v3_x;
    logic signed [COORD_W-1:0] v3_y;
    logic signed [COORD_W-1:0] v3_z;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_a_x;
    logic signed [COORD_W-1:0] out_a_y;
    logic signed [COORD_W-1:0] out_a_z;
    logic signed [COORD_W-1:0] out_b_x;
    logic signed [COORD_W-1:0] out_b_y;
    logic signed [COORD_W-1:0] out_b_z;
    logic signed [COORD_W-1:0] out_c_x;
    logic signed [COORD_W-1:0] out_c_y;
    logic signed [COORD_W-1:0] out_c_z;
    logic                      last_triangle;
  } out_t;

  // Handshake between the sequencer and the normalize unit.
  typedef struct packed {
    logic start;
    logic done;
  } norm_ctl_t;

  // Slot within the parent level that feeds vertex v of child k.
  function automatic logic [2:0] child_src(input logic [1:0] k, input logic [1:0] v);
    logic [2:0] s;
    s = 3'd0;
    unique case (k)
      2'd0: s = (v == 2'd0) ? 3'd0 : (v == 2'd1) ? 3'd3 : 3'd5;
      2'd1: s = (v == 2'd0) ? 3'd1 : (v == 2'd1) ? 3'd4 : 3'd3;
      2'd2: s = (v == 2'd0) ? 3'd2 : (v == 2'd1) ? 3'd5 : 3'd4;
      2'd3: s = (v == 2'd0) ? 3'd3 : (v == 2'd1) ? 3'd4 : 3'd5;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  // Second endpoint of midpoint pair p: (0,1), (1,2), (2,0).
  function automatic logic [1:0] pair_b(input logic [1:0] p);
    return (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

endpackage

// ===== hw/rtl/sphere_triangle_subdivider.sv =====
// Top level: depth-first subdivision sequencer, vertex store and output register.
// Depends on sts_pkg and sts_norm_unit.
//
//  channel | ports                      | transfer
//  input   | start, busy, in_data       | edge with start high and busy low
//  result  | out_valid, out_data        | every cycle out_valid is high
//  config  | cfg_we, cfg_wdata          | edge with cfg_we high
//
// Each midpoint is made in turn: two store reads, a launch state, then the shared
// normalize unit (square steps, root steps, three divides of set-up and bit steps, done).
// Reset is synchronous; the vertex store needs no clearing. Results cannot be stalled.
module sphere_triangle_subdivider #(
  parameter int MAX_DEPTH       = sts_pkg::MAX_DEPTH_DEF,
  parameter int COORD_FRAC_BITS = sts_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  sts_pkg::in_t    in_data,
  output logic            out_valid,
  output sts_pkg::out_t   out_data,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_wdata
);

  localparam int LVLS    = MAX_DEPTH + 1;
  localparam int LW      = $clog2(LVLS);
  localparam int ENTRIES = LVLS * sts_pkg::SLOTS_PER_LEVEL;
  localparam int AW      = $clog2(ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_TRI, S_MID_RA, S_MID_RB, S_MID_GO, S_MID_WAIT,
    S_CP_RD, S_CP_WR, S_LF_RD, S_LF_CAP, S_POP
  } state_t;

  state_t            state_r;
  logic [1:0]        depth_cfg_r;
  sts_pkg::in_t      in_r;
  logic [LW-1:0]     level_r;
  logic [1:0]        cpos_r [LVLS];
  logic [1:0]        v_r;
  logic [1:0]        p_r;
  sts_pkg::vec_t     a_r;
  sts_pkg::vec_t     tri_r [3];
  logic              out_valid_r;
  logic              last_r;

  sts_pkg::vec_t     mem [ENTRIES];
  sts_pkg::vec_t     rd_r;
  logic [AW-1:0]     rd_addr;
  logic              we;
  logic [AW-1:0]     wa;
  sts_pkg::vec_t     wd;

  sts_pkg::norm_ctl_t nctl;
  logic               norm_done;
  sts_pkg::vec_t      norm_m;

  logic [LW-1:0]     depth_eff;
  logic [AW-1:0]     base;
  logic              last_c;
  logic [LW-1:0]     up;

  function automatic sts_pkg::vec_t in_vertex(input sts_pkg::in_t d, input logic [1:0] v);
    sts_pkg::vec_t r;
    r = '{x: d.v1_x, y: d.v1_y, z: d.v1_z};
    if (v == 2'd1) r = '{x: d.v2_x, y: d.v2_y, z: d.v2_z};
    if (v == 2'd2) r = '{x: d.v3_x, y: d.v3_y, z: d.v3_z};
    return r;
  endfunction

  always_comb begin
    depth_eff = (32'(depth_cfg_r) > MAX_DEPTH) ? LW'(MAX_DEPTH) : LW'(depth_cfg_r);
    base      = AW'(level_r) * AW'(sts_pkg::SLOTS_PER_LEVEL);
    up        = level_r - LW'(1);
    // Final triangle once every expanded level sits on its last child.
    last_c = 1'b1;
    for (int i = 0; i < LVLS; i++) begin
      if (LW'(i) < depth_eff && cpos_r[i] != sts_pkg::CHILD_LAST) last_c = 1'b0;
    end
  end

  always_comb begin
    rd_addr = '0;
    unique case (state_r)
      S_MID_RA: rd_addr = base + AW'(p_r);
      S_MID_RB: rd_addr = base + AW'(sts_pkg::pair_b(p_r));
      S_CP_RD:  rd_addr = base + AW'(sts_pkg::child_src(cpos_r[level_r], v_r));
      S_LF_RD:  rd_addr = base + AW'(v_r);
      default:  rd_addr = '0;
    endcase
  end

  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = rd_r;
    unique case (state_r)
      S_LOAD: begin
        we = 1'b1;
        wa = AW'(v_r);
        wd = in_vertex(in_r, v_r);
      end
      S_MID_WAIT: begin
        we = nctl.done;
        wa = base + AW'(sts_pkg::MID_BASE) + AW'(p_r);
        wd = norm_m;
      end
      S_CP_WR: begin
        we = 1'b1;
        wa = base + AW'(sts_pkg::SLOTS_PER_LEVEL) + AW'(v_r);
        wd = rd_r;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[rd_addr];
  end

  assign nctl = '{start: (state_r == S_MID_GO), done: norm_done};

  sts_norm_unit #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (nctl.start),
    .a     (a_r),
    .b     (rd_r),
    .done  (norm_done),
    .m     (norm_m)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_cfg_r <= 2'd0;
      level_r     <= '0;
      v_r         <= 2'd0;
      p_r         <= 2'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LVLS; i++) cpos_r[i] <= 2'd0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) depth_cfg_r <= cfg_wdata;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            in_r    <= in_data;
            level_r <= '0;
            v_r     <= 2'd0;
            for (int i = 0; i < LVLS; i++) cpos_r[i] <= 2'd0;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          v_r <= v_r + 2'd1;
          if (v_r == 2'd2) begin
            v_r     <= 2'd0;
            state_r <= S_TRI;
          end
        end
        S_TRI: begin
          v_r     <= 2'd0;
          p_r     <= 2'd0;
          state_r <= (level_r == depth_eff) ? S_LF_RD : S_MID_RA;
        end
        S_MID_RA: state_r <= S_MID_RB;
        S_MID_RB: begin
          a_r     <= rd_r;
          state_r <= S_MID_GO;
        end
        S_MID_GO: state_r <= S_MID_WAIT;
        S_MID_WAIT: begin
          if (nctl.done) begin
            p_r <= p_r + 2'd1;
            if (p_r == 2'd2) begin
              cpos_r[level_r] <= 2'd0;
              v_r             <= 2'd0;
              state_r         <= S_CP_RD;
            end else begin
              state_r <= S_MID_RA;
            end
          end
        end
        S_CP_RD: state_r <= S_CP_WR;
        S_CP_WR: begin
          v_r <= v_r + 2'd1;
          if (v_r == 2'd2) begin
            level_r <= level_r + LW'(1);
            state_r <= S_TRI;
          end else begin
            state_r <= S_CP_RD;
          end
        end
        S_LF_RD: state_r <= S_LF_CAP;
        S_LF_CAP: begin
          tri_r[v_r] <= rd_r;
          v_r        <= v_r + 2'd1;
          if (v_r == 2'd2) begin
            out_valid_r <= 1'b1;
            last_r      <= last_c;
            state_r     <= S_POP;
          end else begin
            state_r <= S_LF_RD;
          end
        end
        S_POP: begin
          // Climb until a level still has children left to expand.
          if (level_r == '0) begin
            state_r <= S_IDLE;
          end else if (cpos_r[up] == sts_pkg::CHILD_LAST) begin
            level_r <= up;
          end else begin
            cpos_r[up] <= cpos_r[up] + 2'd1;
            level_r    <= up;
            v_r        <= 2'd0;
            state_r    <= S_CP_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = '{
    out_a_x: tri_r[0].x, out_a_y: tri_r[0].y, out_a_z: tri_r[0].z,
    out_b_x: tri_r[1].x, out_b_y: tri_r[1].y, out_b_z: tri_r[1].z,
    out_c_x: tri_r[2].x, out_c_y: tri_r[2].y, out_c_z: tri_r[2].z,
    last_triangle: last_r
  };

`ifndef SYNTHESIS
  a_out_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside an item");
  a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> level_r <= depth_eff)
    else $error("subdivision level passed the depth");
  a_norm_only_wait: assert property (@(posedge clk) disable iff (!rst_n)
    nctl.done |-> state_r == S_MID_WAIT)
    else $error("normalize finished while not awaited");
`endif

endmodule

// ===== hw/rtl/sts_norm_unit.sv =====
// Multi-cycle normalize unit: m = (a+b) * 2^FRAC / isqrt(|a+b|^2), truncated.
// Uses sts_pkg for vec_t and its constants; one multiplier serves all three components.
module sts_norm_unit #(
  parameter int COORD_FRAC_BITS = sts_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  sts_pkg::vec_t     a,
  input  sts_pkg::vec_t     b,
  output logic              done,
  output sts_pkg::vec_t     m
);

  localparam int SW   = sts_pkg::COORD_W + 1;
  localparam int PW   = 2 * SW;
  localparam int SQW  = PW + 1;
  localparam int LENW = SW + 1;
  localparam int QW   = COORD_FRAC_BITS + 1;
  localparam int JW   = $clog2(QW);
  localparam logic [SQW-1:0] BIT_TOP = SQW'(1) << (SQW - 1);

  typedef enum logic [2:0] {N_IDLE, N_SQ, N_RT, N_DVI, N_DV, N_DONE} nstate_t;

  nstate_t                state_r;
  logic signed [SW-1:0]   s_r [3];
  logic [1:0]             ci_r;
  logic [PW-1:0]          acc_r;
  logic [SQW-1:0]         n_r;
  logic [SQW-1:0]         root_r;
  logic [SQW-1:0]         bit_r;
  logic [LENW-1:0]        len_r;
  logic [LENW-1:0]        rem_r;
  logic [QW-1:0]          q_r;
  logic [JW-1:0]          j_r;
  logic signed [sts_pkg::COORD_W-1:0] m_r [3];

  logic [SW-1:0]   mag;
  logic [PW-1:0]   prod;
  logic [SQW-1:0]  rb;
  logic [LENW:0]   t;
  logic            ge;
  logic [QW-1:0]   q_new;
  logic [sts_pkg::COORD_W-1:0] q_ext;

  always_comb begin
    mag   = s_r[ci_r][SW-1] ? SW'(-s_r[ci_r]) : SW'(s_r[ci_r]);
    prod  = PW'(mag) * PW'(mag);
    rb    = root_r + bit_r;
    t     = {rem_r, (j_r == JW'(COORD_FRAC_BITS)) ? mag[0] : 1'b0};
    ge    = t >= {1'b0, len_r};
    q_new = {q_r[QW-2:0], ge};
    q_ext = sts_pkg::COORD_W'(q_new);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      ci_r    <= 2'd0;
    end else begin
      unique case (state_r)
        N_IDLE: begin
          if (start) begin
            s_r[0]  <= SW'(a.x) + SW'(b.x);
            s_r[1]  <= SW'(a.y) + SW'(b.y);
            s_r[2]  <= SW'(a.z) + SW'(b.z);
            ci_r    <= 2'd0;
            acc_r   <= '0;
            state_r <= N_SQ;
          end
        end
        N_SQ: begin
          acc_r <= acc_r + prod;
          if (ci_r == 2'd2) begin
            n_r     <= SQW'(acc_r) + SQW'(prod);
            root_r  <= '0;
            bit_r   <= BIT_TOP;
            ci_r    <= 2'd0;
            state_r <= N_RT;
          end else begin
            ci_r <= ci_r + 2'd1;
          end
        end
        N_RT: begin
          if (n_r >= rb) begin
            n_r    <= n_r - rb;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            len_r   <= (n_r >= rb) ? LENW'((root_r >> 1) + bit_r) : LENW'(root_r >> 1);
            state_r <= N_DVI;
          end
        end
        N_DVI: begin
          rem_r   <= LENW'(mag >> 1);
          q_r     <= '0;
          j_r     <= JW'(COORD_FRAC_BITS);
          state_r <= N_DV;
        end
        N_DV: begin
          rem_r <= ge ? LENW'(t - {1'b0, len_r}) : LENW'(t);
          q_r   <= q_new;
          j_r   <= j_r - JW'(1);
          if (j_r == '0) begin
            // A zero length normalizes to the zero vector.
            if (len_r == '0) m_r[ci_r] <= '0;
            else m_r[ci_r] <= s_r[ci_r][SW-1] ? -q_ext : q_ext;
            if (ci_r == 2'd2) begin
              state_r <= N_DONE;
            end else begin
              ci_r    <= ci_r + 2'd1;
              state_r <= N_DVI;
            end
          end
        end
        N_DONE: begin
          state_r <= N_IDLE;
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

  assign done = (state_r == N_DONE);
  assign m    = '{x: m_r[0], y: m_r[1], z: m_r[2]};

endmodule
